// ===== hw/rtl/rrlp_pkg.sv =====
// shared types and constants for the record ring log pointer
`timescale 1ns / 1ps

package rrlp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_OFF,
        ST_DIV_TOTAL,
        ST_DIV_OLD,
        ST_DIV_POS,
        ST_MUL_POS,
        ST_WRITE
    } rrlp_state_t;

    localparam int unsigned MUL_A_W   = 32;
    localparam int unsigned MUL_B_W   = 16;
    localparam int unsigned MUL_CNT_W = 5;
    localparam int unsigned DIV_W     = 30;
    localparam int unsigned DIV_CNT_W = 5;

    localparam int unsigned START_BITS = 16;
    localparam int unsigned FSECT_BITS = 13;

    localparam int unsigned SEQ_W    = 31;
    localparam int unsigned OFF_W    = 28;
    localparam int unsigned REGION_W = 30;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SECTORS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECTOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_CAPACITY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS    = 3'd5;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_LOCATE = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

endpackage

// ===== hw/rtl/record_ring_log_pointer.sv =====
// top level: head/tail tracking of a circular record log in flash
//
// Input channel in_valid/in_ready carries one item: mode, length,
// record_index, byte_offset. Output channel out_valid/out_ready returns one
// result item per input item, in order. Configuration writes go through
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data; writing
// only while idle is up to the user, since the block does not enforce it.
// An item is taken only in the idle state; the previous result may still be
// waiting in the output register, which holds until out_ready.
// An append runs a 16-bit serial multiply for the region start, then a
// 30-step serial divide for the sector check. A locate runs up to three
// 30-step divides sharing one divider, then a serial slot multiply; a
// locate whose index misses the log skips all of these.
// One item is worked on at a time. A finished result waits in the
// sequencer while the output register is still full.
// Reset empties the log and loads the default configuration.
`timescale 1ns / 1ps

module record_ring_log_pointer #(
    parameter int unsigned HEADER_BYTES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [12:0]                       length,
    input  logic [20:0]                       record_index,
    input  logic [11:0]                       byte_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic                              erase_request,
    output logic [31:0]                       erase_address,
    output logic [31:0]                       entry_address,
    output logic [31:0]                       data_address,
    output logic [30:0]                       sequence_number,
    output logic [12:0]                       data_length,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rrlp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);
    import rrlp_pkg::*;

    localparam int unsigned SLOT_W = $clog2(8191 + HEADER_BYTES + 1);

    rrlp_state_t state_reg, state_next;

    // configuration
    logic [16:0] sector_size_reg;
    logic [12:0] record_size_reg;
    logic [12:0] file_sectors_reg;
    logic [15:0] start_sector_reg;
    logic [20:0] record_capacity_reg;
    logic [31:0] base_address_reg;

    // log state
    logic [SEQ_W-1:0] newest_seq_reg;
    logic             newest_valid_reg;
    logic [OFF_W-1:0] newest_offset_reg;
    logic [SEQ_W-1:0] oldest_seq_reg;
    logic             oldest_valid_reg;
    logic [OFF_W-1:0] oldest_offset_reg;
    logic [20:0]      record_count_reg;

    // item and work registers
    logic                nf_reg;
    logic                mode_reg;
    logic [12:0]         length_reg;
    logic [20:0]         idx_reg;
    logic [11:0]         boff_reg;
    logic [31:0]         start_reg;
    logic [REGION_W-1:0] region_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [DIV_W-1:0]    total_reg;

    // result registers
    logic        out_valid_reg;
    logic        status_reg;
    logic        erase_request_reg;
    logic [31:0] erase_address_reg;
    logic [31:0] entry_address_reg;
    logic [31:0] data_address_reg;
    logic [30:0] sequence_number_reg;
    logic [12:0] data_length_reg;

    // units
    logic                 mul_s_start, mul_s_done;
    logic [MUL_A_W-1:0]   mul_s_product;
    logic                 mul_r_start, mul_r_done;
    logic [MUL_A_W-1:0]   mul_r_a;
    logic [MUL_B_W-1:0]   mul_r_b;
    logic [MUL_CNT_W-1:0] mul_r_n;
    logic [MUL_A_W-1:0]   mul_r_product;
    logic                 div_start, div_done;
    logic [DIV_W-1:0]     div_dividend, div_divisor, div_quot, div_rem;

    logic load_out;
    logic item_nf;

    // datapath terms
    logic [16:0]         ss_eff;
    logic [SLOT_W-1:0]   slot;
    logic [REGION_W-1:0] region_now;
    logic [OFF_W:0]      off_a;
    logic [OFF_W+2:0]    off_end;
    logic [OFF_W-1:0]    off_c;
    logic [OFF_W:0]      old_a;
    logic [OFF_W+2:0]    old_end;
    logic [OFF_W-1:0]    old_c;
    logic [17:0]         rem_sum;
    logic                app_erase;
    logic [31:0]         app_entry;
    logic [SEQ_W-1:0]    seq_inc;
    logic [12:0]         app_len;
    logic [31:0]         loc_entry;
    logic [12:0]         avail;
    logic [12:0]         loc_len;

    assign ss_eff     = (sector_size_reg == '0) ? 17'd1 : sector_size_reg;
    assign slot       = SLOT_W'(record_size_reg) + SLOT_W'(HEADER_BYTES);
    assign region_now = mul_r_product[REGION_W-1:0];

    // next append slot, wrapping when it would pass the region end
    assign off_a   = {1'b0, newest_offset_reg} + (newest_valid_reg ? (OFF_W+1)'(slot) : '0);
    assign off_end = (OFF_W+3)'(off_a) + (OFF_W+3)'(slot);
    assign off_c   = (off_end > (OFF_W+3)'(region_now)) ? '0 : off_a[OFF_W-1:0];

    assign old_a   = {1'b0, oldest_offset_reg} + (OFF_W+1)'(slot);
    assign old_end = (OFF_W+3)'(old_a) + (OFF_W+3)'(slot);
    assign old_c   = (old_end > (OFF_W+3)'(region_reg)) ? '0 : old_a[OFF_W-1:0];

    // slot crosses a sector boundary when offset mod sector plus slot reaches it
    assign rem_sum   = 18'(div_rem[16:0]) + 18'(slot);
    assign app_erase = (off_reg == '0) || (rem_sum >= 18'(ss_eff));
    assign app_entry = start_reg + 32'(off_reg);
    assign seq_inc   = newest_seq_reg + 1'b1;
    assign app_len   = (length_reg > record_size_reg) ? record_size_reg : length_reg;

    assign loc_entry = start_reg + mul_r_product;
    assign avail     = ({1'b0, boff_reg} >= record_size_reg) ? '0
                     : record_size_reg - {1'b0, boff_reg};
    assign loc_len   = (length_reg > avail) ? avail : length_reg;

    assign item_nf = (mode == MODE_LOCATE)
                   && (!oldest_valid_reg || (record_index >= record_count_reg));

    // unit operand selection
    always_comb
    begin
        if (state_reg == ST_DIV_POS)
        begin
            mul_r_a = MUL_A_W'(div_rem);
            mul_r_b = MUL_B_W'(slot);
            mul_r_n = MUL_CNT_W'(SLOT_W);
        end
        else
        begin
            mul_r_a = MUL_A_W'(ss_eff);
            mul_r_b = MUL_B_W'(file_sectors_reg);
            mul_r_n = MUL_CNT_W'(FSECT_BITS);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_MUL:
            begin
                if (mode_reg == MODE_APPEND)
                begin
                    div_dividend = DIV_W'(off_c);
                    div_divisor  = DIV_W'(ss_eff);
                end
                else
                begin
                    div_dividend = DIV_W'(region_now);
                    div_divisor  = DIV_W'(slot);
                end
            end
            ST_DIV_TOTAL:
            begin
                div_dividend = DIV_W'(oldest_offset_reg);
                div_divisor  = DIV_W'(slot);
            end
            default:
            begin
                div_dividend = div_quot + DIV_W'(idx_reg);
                div_divisor  = total_reg;
            end
        endcase
    end

    rrlp_mul u_mul_start (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_s_start),
        .a       (MUL_A_W'(ss_eff)),
        .b       (MUL_B_W'(start_sector_reg)),
        .nbits   (MUL_CNT_W'(START_BITS)),
        .done    (mul_s_done),
        .product (mul_s_product)
    );

    rrlp_mul u_mul_region (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_r_start),
        .a       (mul_r_a),
        .b       (mul_r_b),
        .nbits   (mul_r_n),
        .done    (mul_r_done),
        .product (mul_r_product)
    );

    rrlp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        mul_s_start = 1'b0;
        mul_r_start = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (item_nf)
                        state_next = ST_WRITE;
                    else
                    begin
                        mul_s_start = 1'b1;
                        mul_r_start = 1'b1;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_s_done)
                begin
                    div_start  = 1'b1;
                    state_next = (mode_reg == MODE_APPEND) ? ST_DIV_OFF : ST_DIV_TOTAL;
                end
            end
            ST_DIV_OFF:
            begin
                if (div_done)
                    state_next = ST_WRITE;
            end
            ST_DIV_TOTAL:
            begin
                if (div_done)
                begin
                    if (div_quot == '0)
                        state_next = ST_WRITE;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_OLD;
                    end
                end
            end
            ST_DIV_OLD:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_POS;
                end
            end
            ST_DIV_POS:
            begin
                if (div_done)
                begin
                    mul_r_start = 1'b1;
                    state_next  = ST_MUL_POS;
                end
            end
            ST_MUL_POS:
            begin
                if (mul_r_done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration, log state and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_size_reg     <= 17'd4096;
            record_size_reg     <= 13'd16;
            file_sectors_reg    <= 13'd2;
            start_sector_reg    <= '0;
            record_capacity_reg <= 21'd1;
            base_address_reg    <= '0;
            newest_seq_reg      <= '0;
            newest_valid_reg    <= 1'b0;
            newest_offset_reg   <= '0;
            oldest_seq_reg      <= '0;
            oldest_valid_reg    <= 1'b0;
            oldest_offset_reg   <= '0;
            record_count_reg    <= '0;
            nf_reg              <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SECTOR_SIZE:     sector_size_reg     <= cfg_data[16:0];
                    CFG_RECORD_SIZE:     record_size_reg     <= cfg_data[12:0];
                    CFG_FILE_SECTORS:    file_sectors_reg    <= cfg_data[12:0];
                    CFG_START_SECTOR:    start_sector_reg    <= cfg_data[15:0];
                    CFG_RECORD_CAPACITY: record_capacity_reg <= cfg_data[20:0];
                    CFG_BASE_ADDRESS:    base_address_reg    <= cfg_data;
                    default:             ;
                endcase
            end

            if (state_reg == ST_IDLE && in_valid)
                nf_reg <= item_nf;
            else if (state_reg == ST_DIV_TOTAL && div_done && div_quot == '0)
                nf_reg <= 1'b1;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (load_out && !nf_reg && mode_reg == MODE_APPEND)
            begin
                newest_seq_reg    <= seq_inc;
                newest_valid_reg  <= 1'b1;
                newest_offset_reg <= off_reg;
                if (record_count_reg < record_capacity_reg)
                begin
                    record_count_reg <= record_count_reg + 1'b1;
                    if (!oldest_valid_reg)
                    begin
                        oldest_seq_reg    <= seq_inc;
                        oldest_offset_reg <= off_reg;
                        oldest_valid_reg  <= 1'b1;
                    end
                end
                else
                begin
                    // full: drop the oldest record
                    oldest_seq_reg    <= oldest_seq_reg + 1'b1;
                    oldest_offset_reg <= old_c;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            mode_reg   <= mode;
            length_reg <= length;
            idx_reg    <= record_index;
            boff_reg   <= byte_offset;
        end

        if (state_reg == ST_MUL && mul_s_done)
        begin
            start_reg  <= base_address_reg + mul_s_product;
            region_reg <= region_now;
            off_reg    <= off_c;
        end

        if (state_reg == ST_DIV_TOTAL && div_done)
            total_reg <= div_quot;

        if (load_out)
        begin
            if (nf_reg)
            begin
                status_reg          <= STATUS_NOT_FOUND;
                erase_request_reg   <= 1'b0;
                erase_address_reg   <= '0;
                entry_address_reg   <= '0;
                data_address_reg    <= '0;
                sequence_number_reg <= '0;
                data_length_reg     <= '0;
            end
            else if (mode_reg == MODE_APPEND)
            begin
                status_reg          <= STATUS_OK;
                erase_request_reg   <= app_erase;
                erase_address_reg   <= app_erase ? app_entry + 32'(slot) : '0;
                entry_address_reg   <= app_entry;
                data_address_reg    <= app_entry + 32'(HEADER_BYTES);
                sequence_number_reg <= seq_inc;
                data_length_reg     <= app_len;
            end
            else
            begin
                status_reg          <= STATUS_OK;
                erase_request_reg   <= 1'b0;
                erase_address_reg   <= '0;
                entry_address_reg   <= loc_entry;
                data_address_reg    <= loc_entry + 32'(HEADER_BYTES) + 32'(boff_reg);
                sequence_number_reg <= oldest_seq_reg + SEQ_W'(idx_reg);
                data_length_reg     <= loc_len;
            end
        end
    end

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign erase_request   = erase_request_reg;
    assign erase_address   = erase_address_reg;
    assign entry_address   = entry_address_reg;
    assign data_address    = data_address_reg;
    assign sequence_number = sequence_number_reg;
    assign data_length     = data_length_reg;

endmodule

// ===== hw/rtl/rrlp_mul.sv =====
// bit-serial shift-add multiplier, product modulo 2^32
`timescale 1ns / 1ps

module rrlp_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rrlp_pkg::MUL_A_W-1:0]   a,
    input  logic [rrlp_pkg::MUL_B_W-1:0]   b,
    input  logic [rrlp_pkg::MUL_CNT_W-1:0] nbits,
    output logic                          done,
    output logic [rrlp_pkg::MUL_A_W-1:0]   product
);
    import rrlp_pkg::*;

    logic                 busy_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   acc_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]   b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= nbits;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            else
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= {a_reg[MUL_A_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = busy_reg && (cnt_reg == '0);
    assign product = acc_reg;

endmodule

// ===== hw/rtl/rrlp_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rrlp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rrlp_pkg::DIV_W-1:0] dividend,
    input  logic [rrlp_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [rrlp_pkg::DIV_W-1:0] quotient,
    output logic [rrlp_pkg::DIV_W-1:0] remainder
);
    import rrlp_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     qd_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     d_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, qd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            else
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qd_reg  <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            // dividend bits shift out the top, quotient bits shift in below
            rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            qd_reg  <= {qd_reg[DIV_W-2:0], ge};
        end
    end

    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = qd_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/rrlp_checker.sv =====
// port-level checker for the record ring log pointer, bound to the top level
`timescale 1ns / 1ps

module rrlp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic        erase_request,
    input logic [31:0] erase_address,
    input logic [31:0] entry_address,
    input logic [31:0] data_address,
    input logic [30:0] sequence_number,
    input logic [12:0] data_length
);
    import rrlp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(entry_address) && $stable(data_address)
            && $stable(sequence_number) && $stable(status))
        else $error("result item changed while stalled");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_NOT_FOUND |-> !erase_request
            && entry_address == '0 && data_address == '0
            && sequence_number == '0 && data_length == '0)
        else $error("not-found item carries nonzero fields");

    a_no_erase_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !erase_request |-> erase_address == '0)
        else $error("erase address without erase request");

endmodule

bind record_ring_log_pointer rrlp_checker u_rrlp_checker (.*);
